@@ rtl/sqtd_pkg.sv @@
// package: shared widths, codes, types and helpers of the shortest queue dispatcher
`timescale 1ns / 1ps

package sqtd_pkg;

  localparam int unsigned NumStationsDef = 8;
  localparam int unsigned QueueDepthDef  = 16;
  localparam int unsigned MaxStations    = 8;

  localparam int unsigned OpW      = 2;
  localparam int unsigned LenW     = 16;
  localparam int unsigned PeerW    = 5;
  localparam int unsigned StaW     = 3;
  localparam int unsigned ActW     = 3;
  localparam int unsigned CntOutW  = 5;
  localparam int unsigned LimitW   = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 5;

  localparam logic [LimitW-1:0] QueueLimitRst = 5'd16;
  localparam logic              LocalOnlyRst  = 1'b1;
  localparam logic [StaW-1:0]   OwnIndexRst   = 3'd0;

  typedef enum logic [OpW-1:0] {
    OP_NEW  = 2'd0,
    OP_FWD  = 2'd1,
    OP_DONE = 2'd2
  } opcode_e;

  typedef enum logic [ActW-1:0] {
    ACT_QUEUED    = 3'd0,
    ACT_STARTED   = 3'd1,
    ACT_FORWARDED = 3'd2,
    ACT_DROPPED   = 3'd3,
    ACT_IDLE      = 3'd4
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_QUEUE_LIMIT = 2'd0,
    CFG_LOCAL_ONLY  = 2'd1,
    CFG_OWN_INDEX   = 2'd2
  } cfg_idx_e;

  typedef logic [PeerW-1:0] peer_len_t;

  typedef struct packed {
    logic            found;
    logic [StaW-1:0] who;
    peer_len_t       best;
  } peer_pick_t;

  // zero length is served as one
  function automatic logic [LenW-1:0] served_len(input logic [LenW-1:0] len);
    served_len = (len == '0) ? LenW'(1) : len;
  endfunction

endpackage

@@ rtl/sqtd_if.sv @@
// interfaces: task input, result output and configuration write channels
`timescale 1ns / 1ps

interface sqtd_in_if;
  logic                             valid;
  logic                             ready;
  logic [sqtd_pkg::OpW-1:0]         opcode;
  logic [sqtd_pkg::LenW-1:0]        task_length;
  logic [sqtd_pkg::PeerW-1:0]       peer_len_0;
  logic [sqtd_pkg::PeerW-1:0]       peer_len_1;
  logic [sqtd_pkg::PeerW-1:0]       peer_len_2;
  logic [sqtd_pkg::PeerW-1:0]       peer_len_3;
  logic [sqtd_pkg::PeerW-1:0]       peer_len_4;
  logic [sqtd_pkg::PeerW-1:0]       peer_len_5;
  logic [sqtd_pkg::PeerW-1:0]       peer_len_6;
  logic [sqtd_pkg::PeerW-1:0]       peer_len_7;

  modport source (
    output valid, opcode, task_length, peer_len_0, peer_len_1, peer_len_2, peer_len_3,
           peer_len_4, peer_len_5, peer_len_6, peer_len_7,
    input  ready
  );
  modport sink (
    input  valid, opcode, task_length, peer_len_0, peer_len_1, peer_len_2, peer_len_3,
           peer_len_4, peer_len_5, peer_len_6, peer_len_7,
    output ready
  );
endinterface

interface sqtd_out_if;
  logic                          valid;
  logic                          ready;
  logic [sqtd_pkg::ActW-1:0]     action;
  logic [sqtd_pkg::StaW-1:0]     target_station;
  logic [sqtd_pkg::LenW-1:0]     service_length;
  logic [sqtd_pkg::CntOutW-1:0]  waiting_count;

  modport source (
    output valid, action, target_station, service_length, waiting_count,
    input  ready
  );
  modport sink (
    input  valid, action, target_station, service_length, waiting_count,
    output ready
  );
endinterface

interface sqtd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sqtd_pkg::CfgIdxW-1:0]   idx;
  logic [sqtd_pkg::CfgDataW-1:0]  data;

  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

@@ rtl/shortest_queue_task_dispatcher_top.sv @@
// top level: shortest queue task dispatcher station
//
//  channel   direction  handshake     contents
//  in_i      sink       valid/ready   opcode, task_length, peer_len_0..7
//  out_o     source     valid/ready   action, target_station, service_length, waiting_count
//  cfg_i     sink       valid/ready   idx, data (queue_limit, local_only, own_index)
//
// one transaction per cycle sustained while the result channel is not stalled;
// input register then result register, with the peer search and queue update between them
// a stalled result holds the result register, the input register takes one more transaction
// an unknown opcode is consumed with no result and no state change
// reset clears control, counters and config; queue storage is not cleared
`timescale 1ns / 1ps

module shortest_queue_task_dispatcher_top #(
  parameter int unsigned NUM_STATIONS = sqtd_pkg::NumStationsDef,
  parameter int unsigned QUEUE_DEPTH  = sqtd_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sqtd_in_if.sink     in_i,
  sqtd_out_if.source  out_o,
  sqtd_cfg_if.sink    cfg_i
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LimW = sqtd_pkg::LimitW;
  localparam int unsigned LenW = sqtd_pkg::LenW;

  // configuration
  logic [LimW-1:0]           queue_limit_q;
  logic                      local_only_q;
  logic [sqtd_pkg::StaW-1:0] own_index_q;

  // input register
  logic                      s1_valid_q;
  logic [sqtd_pkg::OpW-1:0]  s1_op_q;
  logic [LenW-1:0]           s1_len_q;
  sqtd_pkg::peer_len_t       s1_peer_q [sqtd_pkg::MaxStations];
  sqtd_pkg::peer_len_t       peer_in   [sqtd_pkg::MaxStations];

  // station state
  logic [LenW-1:0]           fifo_q [QUEUE_DEPTH];
  logic [PtrW-1:0]           head_q, head_d;
  logic [PtrW-1:0]           tail_q, tail_d;
  logic [CntW-1:0]           wait_q, wait_d;
  logic                      busy_q, busy_d;
  logic                      push;

  // result register
  logic                          out_valid_q;
  sqtd_pkg::action_e             out_action_q;
  logic [sqtd_pkg::StaW-1:0]     out_target_q;
  logic [LenW-1:0]               out_svc_q;
  logic [sqtd_pkg::CntOutW-1:0]  out_wait_q;

  sqtd_pkg::action_e             act_d;
  logic [sqtd_pkg::StaW-1:0]     tgt_d;
  logic [LenW-1:0]               svc_d;
  logic                          has_result;
  logic                          keep;
  logic                          s1_take;
  logic [LimW-1:0]               eff_limit;
  logic [LimW-1:0]               wait_ext;
  sqtd_pkg::peer_pick_t          pick;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_limit_q <= sqtd_pkg::QueueLimitRst;
      local_only_q  <= sqtd_pkg::LocalOnlyRst;
      own_index_q   <= sqtd_pkg::OwnIndexRst;
    end else if (cfg_i.valid) begin
      unique case (sqtd_pkg::cfg_idx_e'(cfg_i.idx))
        sqtd_pkg::CFG_QUEUE_LIMIT: queue_limit_q <= cfg_i.data[LimW-1:0];
        sqtd_pkg::CFG_LOCAL_ONLY:  local_only_q  <= cfg_i.data[0];
        sqtd_pkg::CFG_OWN_INDEX:   own_index_q   <= cfg_i.data[sqtd_pkg::StaW-1:0];
        default: ;
      endcase
    end
  end

  assign s1_take    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_take;

  assign peer_in[0] = in_i.peer_len_0;
  assign peer_in[1] = in_i.peer_len_1;
  assign peer_in[2] = in_i.peer_len_2;
  assign peer_in[3] = in_i.peer_len_3;
  assign peer_in[4] = in_i.peer_len_4;
  assign peer_in[5] = in_i.peer_len_5;
  assign peer_in[6] = in_i.peer_len_6;
  assign peer_in[7] = in_i.peer_len_7;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_op_q  <= in_i.opcode;
      s1_len_q <= in_i.task_length;
      s1_peer_q <= peer_in;
    end
  end

  assign eff_limit = (queue_limit_q < LimW'(QUEUE_DEPTH)) ? queue_limit_q : LimW'(QUEUE_DEPTH);
  assign wait_ext  = LimW'(wait_q);

  sqtd_peer_pick #(
    .NumStations (NUM_STATIONS)
  ) u_peer_pick (
    .peer_len_i  (s1_peer_q),
    .own_index_i (own_index_q),
    .limit_i     (eff_limit),
    .pick_o      (pick)
  );

  always_comb begin
    act_d      = sqtd_pkg::ACT_IDLE;
    tgt_d      = '0;
    svc_d      = '0;
    head_d     = head_q;
    tail_d     = tail_q;
    wait_d     = wait_q;
    busy_d     = busy_q;
    push       = 1'b0;
    keep       = 1'b0;
    has_result = 1'b1;

    unique case (sqtd_pkg::opcode_e'(s1_op_q))
      sqtd_pkg::OP_NEW: begin
        if (!local_only_q && pick.found && (wait_ext > pick.best)) begin
          act_d = sqtd_pkg::ACT_FORWARDED;
          tgt_d = pick.who;
        end else begin
          keep = 1'b1;
        end
      end
      sqtd_pkg::OP_FWD: begin
        keep = 1'b1;
      end
      sqtd_pkg::OP_DONE: begin
        if (wait_q != '0) begin
          act_d  = sqtd_pkg::ACT_STARTED;
          svc_d  = sqtd_pkg::served_len(fifo_q[head_q]);
          head_d = (head_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_q + PtrW'(1);
          wait_d = wait_q - CntW'(1);
          busy_d = 1'b1;
        end else begin
          act_d  = sqtd_pkg::ACT_IDLE;
          busy_d = 1'b0;
        end
      end
      default: begin
        has_result = 1'b0;
      end
    endcase

    if (keep) begin
      if (wait_ext >= eff_limit) begin
        act_d = sqtd_pkg::ACT_DROPPED;
      end else if ((wait_q == '0) && !busy_q) begin
        act_d  = sqtd_pkg::ACT_STARTED;
        svc_d  = sqtd_pkg::served_len(s1_len_q);
        busy_d = 1'b1;
      end else begin
        act_d  = sqtd_pkg::ACT_QUEUED;
        push   = 1'b1;
        tail_d = (tail_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PtrW'(1);
        wait_d = wait_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      wait_q <= '0;
      busy_q <= 1'b0;
    end else if (s1_take && has_result) begin
      head_q <= head_d;
      tail_q <= tail_d;
      wait_q <= wait_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take && push) begin
      fifo_q[tail_q] <= s1_len_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_take) begin
      out_valid_q <= has_result;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take && has_result) begin
      out_action_q <= act_d;
      out_target_q <= tgt_d;
      out_svc_q    <= svc_d;
      out_wait_q   <= sqtd_pkg::CntOutW'(wait_d);
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.action         = out_action_q;
  assign out_o.target_station = out_target_q;
  assign out_o.service_length = out_svc_q;
  assign out_o.waiting_count  = out_wait_q;

endmodule

@@ rtl/sqtd_peer_pick.sv @@
// shortest peer queue search: lowest index among the shortest eligible peers
`timescale 1ns / 1ps

module sqtd_peer_pick #(
  parameter int unsigned NumStations = sqtd_pkg::NumStationsDef
) (
  input  sqtd_pkg::peer_len_t              peer_len_i [sqtd_pkg::MaxStations],
  input  logic [sqtd_pkg::StaW-1:0]        own_index_i,
  input  logic [sqtd_pkg::LimitW-1:0]      limit_i,
  output sqtd_pkg::peer_pick_t             pick_o
);

  always_comb begin
    pick_o = '0;
    for (int i = 0; i < NumStations; i++) begin
      // an empty peer always qualifies, others only below the limit
      if ((sqtd_pkg::StaW'(i) != own_index_i) &&
          ((peer_len_i[i] == '0) || (peer_len_i[i] < limit_i))) begin
        if (!pick_o.found || (peer_len_i[i] < pick_o.best)) begin
          pick_o.found = 1'b1;
          pick_o.who   = sqtd_pkg::StaW'(i);
          pick_o.best  = peer_len_i[i];
        end
      end
    end
  end

endmodule

@@ rtl/sqtd_checker.sv @@
// checker: port level properties of the dispatcher result channel, bound to the top level
`timescale 1ns / 1ps

module sqtd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [sqtd_pkg::ActW-1:0]     action_i,
  input logic [sqtd_pkg::StaW-1:0]     target_station_i,
  input logic [sqtd_pkg::LenW-1:0]     service_length_i,
  input logic [sqtd_pkg::CntOutW-1:0]  waiting_count_i
);

  // target only set on forwarding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (action_i != sqtd_pkg::ACT_FORWARDED) |-> target_station_i == '0)
    else $error("target station set without forwarding");

  // service length nonzero exactly when service starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((action_i == sqtd_pkg::ACT_STARTED) == (service_length_i != '0)))
    else $error("service length does not match action");

  // queued leaves something waiting, idle leaves nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (action_i == sqtd_pkg::ACT_QUEUED) |-> waiting_count_i != '0)
    else $error("queued with empty waiting count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (action_i == sqtd_pkg::ACT_IDLE) |-> waiting_count_i == '0)
    else $error("went idle with tasks waiting");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(action_i) &&
      $stable(target_station_i) && $stable(service_length_i) && $stable(waiting_count_i))
    else $error("stalled result changed");

endmodule

bind shortest_queue_task_dispatcher_top sqtd_checker u_sqtd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .action_i         (out_o.action),
  .target_station_i (out_o.target_station),
  .service_length_i (out_o.service_length),
  .waiting_count_i  (out_o.waiting_count)
);

@@ dv/tb_shortest_queue_task_dispatcher_top.sv @@
// testbench: shortest queue dispatcher station, random and directed traffic against a scoreboard
`timescale 1ns / 1ps

module tb_shortest_queue_task_dispatcher_top;

  localparam int unsigned Stations  = sqtd_pkg::NumStationsDef;
  localparam int unsigned Depth     = sqtd_pkg::QueueDepthDef;
  localparam int          NumPhases = 8;
  localparam int          PhaseLen  = 128;
  localparam int          HoldLen   = 60;
  localparam int          HoldMarkA = 300;
  localparam int          HoldMarkB = 650;

  localparam logic [sqtd_pkg::OpW-1:0] OpUnknown = 2'd3;

  localparam int PhaseLimit   [NumPhases] = '{16, 1, 0, 31, 8, 4, 2, 16};
  localparam int PhaseLocal   [NumPhases] = '{0, 0, 0, 1, 0, 0, 1, 0};
  localparam int PhaseOwn     [NumPhases] = '{0, 7, 3, 5, 2, 6, 1, 4};
  localparam int PhaseArrival [NumPhases] = '{70, 60, 50, 75, 65, 55, 80, 60};

  typedef struct packed {
    logic [sqtd_pkg::OpW-1:0]                   opcode;
    logic [sqtd_pkg::LenW-1:0]                  len;
    logic [Stations-1:0][sqtd_pkg::PeerW-1:0]   peer;
  } task_req_t;

  typedef struct packed {
    logic [sqtd_pkg::ActW-1:0]    action;
    logic [sqtd_pkg::StaW-1:0]    target;
    logic [sqtd_pkg::LenW-1:0]    svc_len;
    logic [sqtd_pkg::CntOutW-1:0] waiting;
  } outcome_t;

  class dispatch_scoreboard;
    logic [sqtd_pkg::LenW-1:0]   len_store [Depth];
    int unsigned                 head;
    int unsigned                 tail;
    int unsigned                 waiting;
    bit                          busy;
    logic [sqtd_pkg::LimitW-1:0] limit_reg;
    bit                          local_reg;
    logic [sqtd_pkg::StaW-1:0]   own_reg;
    outcome_t                    pending_outcomes [$];
    int                          errors;
    int                          accepted;

    function new();
      head      = 0;
      tail      = 0;
      waiting   = 0;
      busy      = 1'b0;
      limit_reg = sqtd_pkg::QueueLimitRst;
      local_reg = sqtd_pkg::LocalOnlyRst;
      own_reg   = sqtd_pkg::OwnIndexRst;
      errors    = 0;
      accepted  = 0;
    endfunction

    function void write_cfg(sqtd_pkg::cfg_idx_e idx, logic [sqtd_pkg::CfgDataW-1:0] data);
      case (idx)
        sqtd_pkg::CFG_QUEUE_LIMIT: limit_reg = data;
        sqtd_pkg::CFG_LOCAL_ONLY:  local_reg = data[0];
        sqtd_pkg::CFG_OWN_INDEX:   own_reg   = data[sqtd_pkg::StaW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned cap();
      return (limit_reg < Depth) ? limit_reg : Depth;
    endfunction

    // start, queue or drop a task kept at this station
    function logic [sqtd_pkg::ActW-1:0] keep_local(logic [sqtd_pkg::LenW-1:0] len,
                                                   output logic [sqtd_pkg::LenW-1:0] svc);
      svc = '0;
      if (waiting >= cap()) return sqtd_pkg::ACT_DROPPED;
      if (waiting == 0 && !busy) begin
        busy = 1'b1;
        svc  = (len == '0) ? sqtd_pkg::LenW'(1) : len;
        return sqtd_pkg::ACT_STARTED;
      end
      len_store[tail] = len;
      tail = (tail + 1) % Depth;
      waiting++;
      return sqtd_pkg::ACT_QUEUED;
    endfunction

    function void predict_dispatch(task_req_t t);
      bit                        found;
      bit                        stop;
      int unsigned               best;
      int unsigned               who;
      logic [sqtd_pkg::ActW-1:0] act;
      logic [sqtd_pkg::StaW-1:0] tgt;
      logic [sqtd_pkg::LenW-1:0] svc;
      outcome_t                  e;
      accepted++;
      found = 1'b0;
      stop  = 1'b0;
      best  = 0;
      who   = 0;
      tgt   = '0;
      svc   = '0;
      case (t.opcode)
        sqtd_pkg::OP_NEW: begin
          if (!local_reg) begin
            for (int i = 0; i < Stations && !stop; i++) begin
              if (i != own_reg) begin
                if (t.peer[i] == '0) begin
                  found = 1'b1;
                  who   = i;
                  best  = 0;
                  stop  = 1'b1;
                end else if (t.peer[i] < cap() && (!found || t.peer[i] < best)) begin
                  found = 1'b1;
                  who   = i;
                  best  = t.peer[i];
                end
              end
            end
          end
          if (found && waiting > best) begin
            act = sqtd_pkg::ACT_FORWARDED;
            tgt = sqtd_pkg::StaW'(who);
          end else begin
            act = keep_local(t.len, svc);
          end
        end
        sqtd_pkg::OP_FWD: act = keep_local(t.len, svc);
        sqtd_pkg::OP_DONE: begin
          if (waiting != 0) begin
            svc     = len_store[head];
            svc     = (svc == '0) ? sqtd_pkg::LenW'(1) : svc;
            head    = (head + 1) % Depth;
            waiting--;
            busy    = 1'b1;
            act     = sqtd_pkg::ACT_STARTED;
          end else begin
            busy = 1'b0;
            act  = sqtd_pkg::ACT_IDLE;
          end
        end
        default: return;
      endcase
      e.action  = act;
      e.target  = tgt;
      e.svc_len = svc;
      e.waiting = sqtd_pkg::CntOutW'(waiting);
      pending_outcomes.push_back(e);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(outcome_t got);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        report($sformatf("result with nothing pending, action %0d", got.action));
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.action != want.action)
        report($sformatf("action got %0d want %0d", got.action, want.action));
      if (got.target != want.target)
        report($sformatf("target_station got %0d want %0d", got.target, want.target));
      if (got.svc_len != want.svc_len)
        report($sformatf("service_length got %0d want %0d", got.svc_len, want.svc_len));
      if (got.waiting != want.waiting)
        report($sformatf("waiting_count got %0d want %0d", got.waiting, want.waiting));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   idle_on;

  sqtd_in_if  in_if ();
  sqtd_out_if out_if ();
  sqtd_cfg_if cfg_if ();

  dispatch_scoreboard sb = new();

  shortest_queue_task_dispatcher_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("tb_shortest_queue_task_dispatcher_top: done, errors");
    $finish;
  end

  // result receiver with random stalls and two long hold-offs
  initial begin
    int stall_left;
    int holds_done;
    stall_left   = 0;
    holds_done   = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left == 0 && holds_done < 2 &&
          sb.accepted >= ((holds_done == 0) ? HoldMarkA : HoldMarkB)) begin
        stall_left = HoldLen;
        holds_done++;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    outcome_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.action  = out_if.action;
      got.target  = out_if.target_station;
      got.svc_len = out_if.service_length;
      got.waiting = out_if.waiting_count;
      sb.check_result(got);
    end
  end

  task automatic pause_input(int n);
    repeat (n) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
    end
  endtask

  task automatic send_req(task_req_t t);
    @(negedge clk_i);
    in_if.valid       = 1'b1;
    in_if.opcode      = t.opcode;
    in_if.task_length = t.len;
    in_if.peer_len_0  = t.peer[0];
    in_if.peer_len_1  = t.peer[1];
    in_if.peer_len_2  = t.peer[2];
    in_if.peer_len_3  = t.peer[3];
    in_if.peer_len_4  = t.peer[4];
    in_if.peer_len_5  = t.peer[5];
    in_if.peer_len_6  = t.peer[6];
    in_if.peer_len_7  = t.peer[7];
    do @(posedge clk_i); while (!in_if.ready);
    sb.predict_dispatch(t);
    if (idle_on && $urandom_range(0, 4) == 0) pause_input($urandom_range(1, 3));
  endtask

  task automatic write_reg(sqtd_pkg::cfg_idx_e idx, int value);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.idx   = idx;
    cfg_if.data  = sqtd_pkg::CfgDataW'(value);
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_cfg(idx, sqtd_pkg::CfgDataW'(value));
  endtask

  // wait until every expected result is back, plus the pipeline depth
  task automatic settle();
    pause_input(1);
    while (sb.pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic task_req_t rand_req(int arrival_pct);
    task_req_t t;
    int        r;
    int        pmode;
    r = $urandom_range(0, 99);
    if (r < 2) t.opcode = OpUnknown;
    else if (r < 2 + arrival_pct)
      t.opcode = ($urandom_range(0, 9) < 7) ? sqtd_pkg::OP_NEW : sqtd_pkg::OP_FWD;
    else t.opcode = sqtd_pkg::OP_DONE;
    r = $urandom_range(0, 9);
    t.len = (r == 0) ? '0 : (r == 1) ? '1 : sqtd_pkg::LenW'($urandom);
    pmode = $urandom_range(0, 3);
    for (int i = 0; i < Stations; i++) begin
      case (pmode)
        0: t.peer[i] = sqtd_pkg::PeerW'($urandom_range(0, 16));
        1: t.peer[i] = sqtd_pkg::PeerW'($urandom_range(1, 16));
        2: t.peer[i] = sqtd_pkg::PeerW'($urandom_range(12, 16));
        default: t.peer[i] = sqtd_pkg::PeerW'($urandom_range(0, 3));
      endcase
    end
    return t;
  endfunction

  task automatic directed(logic [sqtd_pkg::OpW-1:0] op, logic [sqtd_pkg::LenW-1:0] len);
    task_req_t t;
    t        = rand_req(50);
    t.opcode = op;
    t.len    = len;
    send_req(t);
  endtask

  initial begin
    task_req_t t;
    int        n;
    idle_on           = 1'b1;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.opcode      = '0;
    in_if.task_length = '0;
    in_if.peer_len_0  = '0;
    in_if.peer_len_1  = '0;
    in_if.peer_len_2  = '0;
    in_if.peer_len_3  = '0;
    in_if.peer_len_4  = '0;
    in_if.peer_len_5  = '0;
    in_if.peer_len_6  = '0;
    in_if.peer_len_7  = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.idx        = sqtd_pkg::CFG_QUEUE_LIMIT;
    cfg_if.data       = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // completion on idle server, zero and full lengths, unknown opcode
    directed(sqtd_pkg::OP_DONE, 16'd7);
    directed(sqtd_pkg::OP_NEW, '0);
    directed(sqtd_pkg::OP_NEW, '1);
    directed(sqtd_pkg::OP_FWD, '0);
    directed(OpUnknown, 16'd5);
    directed(sqtd_pkg::OP_DONE, '0);
    directed(sqtd_pkg::OP_DONE, '0);
    directed(sqtd_pkg::OP_DONE, '0);
    directed(sqtd_pkg::OP_DONE, '0);
    // fill the queue to the limit, then overflow it
    for (int i = 0; i < 18; i++) directed(sqtd_pkg::OP_NEW, sqtd_pkg::LenW'(i * 3641));
    directed(sqtd_pkg::OP_FWD, 16'd99);

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      if (p == NumPhases - 1) idle_on = 1'b0;
      write_reg(sqtd_pkg::CFG_QUEUE_LIMIT, PhaseLimit[p]);
      write_reg(sqtd_pkg::CFG_LOCAL_ONLY, PhaseLocal[p]);
      write_reg(sqtd_pkg::CFG_OWN_INDEX, PhaseOwn[p]);
      @(negedge clk_i);
      cfg_if.valid = 1'b0;
      n = 0;
      while (n < PhaseLen) begin
        t = rand_req(PhaseArrival[p]);
        send_req(t);
        if (t.opcode != OpUnknown) n++;
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending_outcomes.size() == 0) begin
      $display("tb_shortest_queue_task_dispatcher_top: done, clean");
    end else begin
      $display("tb_shortest_queue_task_dispatcher_top: done, errors");
    end
    $finish;
  end

endmodule
